@@ rtl/gpl_pkg.sv @@
// Shared types and constants of the grid point locator.
// Used by gpl_div, gpl_ctrl, gpl_dpath and the top level; depends on nothing.
package gpl_pkg;

    localparam int NUM_CFG     = 6;
    localparam int CFG_IW      = 3;
    localparam int BLK_SLOTS   = 64;
    localparam int CORNER_AW   = 15;
    localparam int CORNER_DEPTH = 32768;
    localparam int DIV_NW      = 56;
    localparam int DIV_DW      = 33;
    localparam int CQW         = 24;

    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [33:0] HALF_Q16 = 34'd32768;

    localparam logic [1:0] ACT_REG   = 2'd0;
    localparam logic [1:0] ACT_NODE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_OUTSIDE  = 2'd3;

    localparam logic [2:0] SLOT_LAST = 3'd7;

    typedef enum logic [17:0] {
        S_CLEAR    = 18'h00001,
        S_IDLE     = 18'h00002,
        S_DISPATCH = 18'h00004,
        S_DIV_GO   = 18'h00008,
        S_DIV_WAIT = 18'h00010,
        S_RANGE    = 18'h00020,
        S_WALK_RD  = 18'h00040,
        S_WALK_WR  = 18'h00080,
        S_FILL_RD  = 18'h00100,
        S_FILL_GET = 18'h00200,
        S_ENT_RD   = 18'h00400,
        S_BLK_RD   = 18'h00800,
        S_CMP      = 18'h01000,
        S_CELL     = 18'h02000,
        S_WMUL1    = 18'h04000,
        S_WMUL2    = 18'h08000,
        S_WEMIT    = 18'h10000,
        S_EMIT1    = 18'h20000
    } t_state;

    typedef struct packed {
        logic       in_ready;
        logic       capture;
        logic       blk_we;
        logic       node_we;
        logic       clear;
        logic       init_bucket;
        logic       init_cell;
        logic       div_start;
        logic       div_store;
        logic       range_ld;
        logic       walk_wr;
        logic       fill_get;
        logic       scan_next;
        logic       hit_ld;
        logic       cell_ld;
        logic       mul1;
        logic       mul2;
        logic       emit_w;
        logic       emit1;
        logic       st_set;
        logic [1:0] st_val;
    } t_cmd;

    typedef struct packed {
        logic [1:0] act;
        logic       clr_last;
        logic       bn_ok;
        logic       outside;
        logic       div_done;
        logic       div_last;
        logic       phase_cell;
        logic       is_query;
        logic       range_ok;
        logic       walk_last;
        logic       scan_end;
        logic       hit;
        logic       s_last;
        logic       out_free;
    } t_sts;

endpackage

@@ rtl/gpl_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses gpl_pkg for operand widths.
module gpl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gpl_pkg::DIV_NW-1:0]    i_num,
    input  logic [gpl_pkg::DIV_DW-1:0]    i_den,
    output logic                          o_done,
    output logic [gpl_pkg::DIV_NW-1:0]    o_quo,
    output logic                          o_rem_nz
);
    localparam int NW = gpl_pkg::DIV_NW;
    localparam int DW = gpl_pkg::DIV_DW;

    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[NW-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_quo    = r_quo;
    assign o_rem_nz = r_rem != '0;
endmodule

@@ rtl/gpl_ctrl.sv @@
// Controller state machine of the grid point locator.
// Uses gpl_pkg for state, command and status types.
module gpl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  gpl_pkg::t_sts i_sts,
    output gpl_pkg::t_cmd o_cmd
);
    gpl_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gpl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            gpl_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) n_state = gpl_pkg::S_IDLE;
            end
            gpl_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = gpl_pkg::S_DISPATCH;
                end
            end
            gpl_pkg::S_DISPATCH: begin
                case (i_sts.act)
                    gpl_pkg::ACT_REG: begin
                        o_cmd.st_set = 1'b1;
                        o_cmd.st_val = gpl_pkg::ST_OK;
                        if (i_sts.bn_ok) begin
                            o_cmd.blk_we      = 1'b1;
                            o_cmd.init_bucket = 1'b1;
                            n_state = gpl_pkg::S_DIV_GO;
                        end else begin
                            n_state = gpl_pkg::S_EMIT1;
                        end
                    end
                    gpl_pkg::ACT_NODE: begin
                        o_cmd.node_we = i_sts.bn_ok;
                        n_state = gpl_pkg::S_IDLE;
                    end
                    gpl_pkg::ACT_QUERY: begin
                        if (i_sts.outside) begin
                            o_cmd.st_set = 1'b1;
                            o_cmd.st_val = gpl_pkg::ST_OUTSIDE;
                            n_state = gpl_pkg::S_EMIT1;
                        end else begin
                            o_cmd.init_bucket = 1'b1;
                            n_state = gpl_pkg::S_DIV_GO;
                        end
                    end
                    default: n_state = gpl_pkg::S_IDLE;
                endcase
            end
            gpl_pkg::S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = gpl_pkg::S_DIV_WAIT;
            end
            gpl_pkg::S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (!i_sts.div_last)      n_state = gpl_pkg::S_DIV_GO;
                    else if (i_sts.phase_cell) n_state = gpl_pkg::S_CELL;
                    else if (i_sts.is_query)   n_state = gpl_pkg::S_FILL_RD;
                    else                       n_state = gpl_pkg::S_RANGE;
                end
            end
            gpl_pkg::S_RANGE: begin
                o_cmd.range_ld = 1'b1;
                n_state = i_sts.range_ok ? gpl_pkg::S_WALK_RD : gpl_pkg::S_EMIT1;
            end
            gpl_pkg::S_WALK_RD: n_state = gpl_pkg::S_WALK_WR;
            gpl_pkg::S_WALK_WR: begin
                o_cmd.walk_wr = 1'b1;
                n_state = i_sts.walk_last ? gpl_pkg::S_EMIT1 : gpl_pkg::S_WALK_RD;
            end
            gpl_pkg::S_FILL_RD: n_state = gpl_pkg::S_FILL_GET;
            gpl_pkg::S_FILL_GET: begin
                o_cmd.fill_get = 1'b1;
                n_state = gpl_pkg::S_ENT_RD;
            end
            gpl_pkg::S_ENT_RD: begin
                if (i_sts.scan_end) begin
                    o_cmd.st_set = 1'b1;
                    o_cmd.st_val = gpl_pkg::ST_NOTFOUND;
                    n_state = gpl_pkg::S_EMIT1;
                end else begin
                    n_state = gpl_pkg::S_BLK_RD;
                end
            end
            gpl_pkg::S_BLK_RD: n_state = gpl_pkg::S_CMP;
            gpl_pkg::S_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.hit_ld    = 1'b1;
                    o_cmd.init_cell = 1'b1;
                    n_state = gpl_pkg::S_DIV_GO;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = gpl_pkg::S_ENT_RD;
                end
            end
            gpl_pkg::S_CELL: begin
                o_cmd.cell_ld = 1'b1;
                n_state = gpl_pkg::S_WMUL1;
            end
            gpl_pkg::S_WMUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = gpl_pkg::S_WMUL2;
            end
            gpl_pkg::S_WMUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = gpl_pkg::S_WEMIT;
            end
            gpl_pkg::S_WEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_w = 1'b1;
                    n_state = i_sts.s_last ? gpl_pkg::S_IDLE : gpl_pkg::S_WMUL1;
                end
            end
            gpl_pkg::S_EMIT1: begin
                if (i_sts.out_free) begin
                    o_cmd.emit1 = 1'b1;
                    n_state = gpl_pkg::S_IDLE;
                end
            end
            default: n_state = gpl_pkg::S_IDLE;
        endcase
    end
endmodule

@@ rtl/gpl_dpath.sv @@
// Datapath of the grid point locator: registers, stores, divider and weights.
// Uses gpl_pkg and instantiates gpl_div.
module gpl_dpath #(
    parameter int MAP_SIZE     = 8,
    parameter int CELLS_X      = 4,
    parameter int CELLS_Y      = 4,
    parameter int CELLS_Z      = 4,
    parameter int MAX_BLOCKS   = 64,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gpl_pkg::t_cmd                 i_cmd,
    output gpl_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_valid,
    input  logic [gpl_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic [1:0]                    i_action,
    input  logic [5:0]                    i_block_number,
    input  logic [5:0]                    i_cell_number,
    input  logic [2:0]                    i_corner_slot,
    input  logic [20:0]                   i_node_number,
    input  logic signed [31:0]            i_pos_x,
    input  logic signed [31:0]            i_pos_y,
    input  logic signed [31:0]            i_pos_z,
    input  logic signed [31:0]            i_upper_x,
    input  logic signed [31:0]            i_upper_y,
    input  logic signed [31:0]            i_upper_z,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_status,
    output logic [2:0]                    o_slot,
    output logic [19:0]                   o_node_index,
    output logic [16:0]                   o_weight,
    output logic                          o_last
);
    localparam int NUM_B = MAP_SIZE * MAP_SIZE * MAP_SIZE;
    localparam int NUM_E = NUM_B * BUCKET_DEPTH;
    localparam int MW    = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
    localparam int NBW   = (NUM_B > 1) ? $clog2(NUM_B) : 1;
    localparam int EAW   = (NUM_E > 1) ? $clog2(NUM_E) : 1;
    localparam int FW    = $clog2(BUCKET_DEPTH + 1);
    localparam int NW    = gpl_pkg::DIV_NW;
    localparam int DW    = gpl_pkg::DIV_DW;
    localparam int CQW   = gpl_pkg::CQW;
    localparam logic signed [40:0] MapS = 41'(MAP_SIZE);

    // configuration registers
    logic signed [31:0] r_cfg [gpl_pkg::NUM_CFG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_cfg[a]     <= '0;
                r_cfg[a + 3] <= 32'sd65536;
            end
        end else if (i_cfg_valid && (int'(i_cfg_index) < gpl_pkg::NUM_CFG)) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // captured item
    logic [1:0]         r_act;
    logic [5:0]         r_bn;
    logic [5:0]         r_cell;
    logic [2:0]         r_cs;
    logic [20:0]        r_node;
    logic signed [31:0] r_p [3];
    logic signed [31:0] r_u [3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= i_action;
            r_bn   <= i_block_number;
            r_cell <= i_cell_number;
            r_cs   <= i_corner_slot;
            r_node <= i_node_number;
            r_p[0] <= i_pos_x;
            r_p[1] <= i_pos_y;
            r_p[2] <= i_pos_z;
            r_u[0] <= i_upper_x;
            r_u[1] <= i_upper_y;
            r_u[2] <= i_upper_z;
        end
    end

    logic bn_ok;
    logic outside;
    assign bn_ok = int'(r_bn) < MAX_BLOCKS;

    always_comb begin
        outside = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (r_p[a] < r_cfg[a] || r_cfg[a + 3] < r_p[a]) outside = 1'b1;
        end
    end

    // division jobs
    logic [2:0]         r_div_idx;
    logic               r_phase_cell;
    logic               r_neg;
    logic               r_zero;
    logic signed [40:0] r_rb [6];
    logic [CQW-1:0]     r_cq [3];
    logic signed [31:0] r_bl [3];
    logic signed [31:0] r_bh [3];

    logic [1:0]         ax;
    logic signed [31:0] sel_v;
    logic signed [31:0] sel_min;
    logic signed [31:0] sel_max;
    logic signed [32:0] b_diff;
    logic signed [32:0] b_ext;
    logic signed [40:0] b_num;
    logic [40:0]        b_mag;
    logic signed [32:0] c_diff;
    logic signed [32:0] c_ext;
    logic [6:0]         cells_a;
    logic [39:0]        c_prod;
    logic [NW-1:0]      div_num;
    logic [DW-1:0]      div_den;
    logic               job_neg;
    logic               job_zero;
    logic               div_done;
    logic [NW-1:0]      div_quo;
    logic               div_rem_nz;

    always_comb begin
        case (r_div_idx)
            3'd0, 3'd3: ax = 2'd0;
            3'd1, 3'd4: ax = 2'd1;
            3'd2, 3'd5: ax = 2'd2;
            default:    ax = 2'd0;
        endcase
        case (ax)
            2'd1:    cells_a = 7'(CELLS_Y);
            2'd2:    cells_a = 7'(CELLS_Z);
            default: cells_a = 7'(CELLS_X);
        endcase
        sel_v   = (r_div_idx >= 3'd3) ? r_u[ax] : r_p[ax];
        sel_min = r_cfg[3'(ax)];
        sel_max = r_cfg[3'(ax) + 3'd3];
        b_diff  = 33'(sel_v) - 33'(sel_min);
        b_ext   = 33'(sel_max) - 33'(sel_min);
        b_num   = 41'(b_diff) * MapS;
        b_mag   = b_num[40] ? 41'(-b_num) : 41'(b_num);
        c_diff  = 33'(r_p[ax]) - 33'(r_bl[ax]);
        c_ext   = 33'(r_bh[ax]) - 33'(r_bl[ax]);
        c_prod  = 40'(c_diff) * 40'(cells_a);
        if (r_phase_cell) begin
            div_num  = {c_prod, 16'd0};
            div_den  = c_ext;
            job_neg  = 1'b0;
            job_zero = c_ext <= 33'sd0;
        end else begin
            div_num  = NW'(b_mag);
            div_den  = b_ext;
            job_neg  = b_num[40];
            job_zero = b_ext <= 33'sd0;
        end
    end

    gpl_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_num    (div_num),
        .i_den    (div_den),
        .o_done   (div_done),
        .o_quo    (div_quo),
        .o_rem_nz (div_rem_nz)
    );

    logic [40:0]        q_mag;
    logic signed [40:0] b_res;

    always_comb begin
        q_mag = 41'(div_quo) + 41'(div_rem_nz & r_neg);
        if (r_zero)     b_res = '0;
        else if (r_neg) b_res = -$signed(q_mag);
        else            b_res = $signed(q_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_bucket) begin
            r_div_idx    <= '0;
            r_phase_cell <= 1'b0;
        end else if (i_cmd.init_cell) begin
            r_div_idx    <= '0;
            r_phase_cell <= 1'b1;
        end else if (i_cmd.div_store) begin
            r_div_idx <= r_div_idx + 3'd1;
        end
        if (i_cmd.div_start) begin
            r_neg  <= job_neg;
            r_zero <= job_zero;
        end
        if (i_cmd.div_store) begin
            if (r_phase_cell) r_cq[ax] <= r_zero ? '0 : CQW'(div_quo);
            else              r_rb[r_div_idx] <= b_res;
        end
    end

    // bucket coordinates
    function automatic logic [MW-1:0] clamp_b(input logic signed [40:0] x);
        if (x < 41'sd0)           return '0;
        else if (x > MapS - 41'sd1) return MW'(MAP_SIZE - 1);
        else                      return MW'(x);
    endfunction

    function automatic logic [NBW-1:0] b_lin(input logic [MW-1:0] i, input logic [MW-1:0] j,
                                             input logic [MW-1:0] k);
        return NBW'((int'(i) * MAP_SIZE + int'(j)) * MAP_SIZE + int'(k));
    endfunction

    logic [MW-1:0]  r_wlo [3];
    logic [MW-1:0]  r_whi [3];
    logic [MW-1:0]  r_wi;
    logic [MW-1:0]  r_wj;
    logic [MW-1:0]  r_wk;
    logic           range_ok;
    logic [MW-1:0]  lo_c [3];
    logic [MW-1:0]  hi_c [3];
    logic [NBW-1:0] wb;
    logic [NBW-1:0] qb;
    logic           walk_last;

    always_comb begin
        range_ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
            lo_c[a] = clamp_b(r_rb[a]);
            hi_c[a] = clamp_b(r_rb[a + 3]);
            if (r_rb[a + 3] < 41'sd0 || r_rb[a] >= MapS) range_ok = 1'b0;
            if (lo_c[a] > hi_c[a]) range_ok = 1'b0;
        end
        wb = b_lin(r_wi, r_wj, r_wk);
        qb = b_lin(clamp_b(r_rb[0]), clamp_b(r_rb[1]), clamp_b(r_rb[2]));
        walk_last = (r_wi == r_whi[0]) && (r_wj == r_whi[1]) && (r_wk == r_whi[2]);
    end

    // stores
    logic [191:0]     mem_blk    [gpl_pkg::BLK_SLOTS];
    logic [19:0]      mem_corner [gpl_pkg::CORNER_DEPTH];
    logic [5:0]       mem_ent    [NUM_E];
    logic [FW-1:0]    mem_fill   [NUM_B];
    logic [191:0]     r_blk_rd;
    logic [19:0]      r_corner_rd;
    logic [5:0]       r_ent_rd;
    logic [FW-1:0]    r_fill_rd;

    logic [NBW-1:0]   r_clr;
    logic [FW-1:0]    r_fill_cnt;
    logic [FW-1:0]    r_n;
    logic [5:0]       r_blk;
    logic [5:0]       r_lin;
    logic [2:0]       r_s;
    logic [16:0]      r_f [3];
    logic [1:0]       r_st;

    logic             fill_full;
    logic [NBW-1:0]   fill_ra;
    logic [EAW-1:0]   ent_ra;
    logic [EAW-1:0]   ent_wa;
    logic [gpl_pkg::CORNER_AW-1:0] corner_ra;

    always_comb begin
        fill_full = int'(r_fill_rd) >= BUCKET_DEPTH;
        fill_ra   = (r_act == gpl_pkg::ACT_QUERY) ? qb : wb;
        ent_ra    = EAW'(int'(qb) * BUCKET_DEPTH + int'(r_n));
        ent_wa    = EAW'(int'(wb) * BUCKET_DEPTH + int'(r_fill_rd));
        corner_ra = {r_blk, r_lin, r_s};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_we) begin
            mem_blk[r_bn] <= {r_p[0], r_p[1], r_p[2], r_u[0], r_u[1], r_u[2]};
        end
        r_blk_rd <= mem_blk[r_ent_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.node_we) begin
            mem_corner[{r_bn, r_cell, r_cs}] <= 20'(r_node - 21'd1);
        end
        r_corner_rd <= mem_corner[corner_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_wr && !fill_full) begin
            mem_ent[ent_wa] <= r_bn;
        end
        r_ent_rd <= mem_ent[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem_fill[r_clr] <= '0;
        end else if (i_cmd.walk_wr && !fill_full) begin
            mem_fill[wb] <= r_fill_rd + FW'(1);
        end
        r_fill_rd <= mem_fill[fill_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + NBW'(1);
        end
    end

    // walk over the overlapped buckets, z fastest
    always_ff @(posedge i_clk) begin
        if (i_cmd.range_ld) begin
            for (int a = 0; a < 3; a++) begin
                r_wlo[a] <= lo_c[a];
                r_whi[a] <= hi_c[a];
            end
            r_wi <= lo_c[0];
            r_wj <= lo_c[1];
            r_wk <= lo_c[2];
        end else if (i_cmd.walk_wr) begin
            if (r_wk != r_whi[2]) begin
                r_wk <= r_wk + MW'(1);
            end else begin
                r_wk <= r_wlo[2];
                if (r_wj != r_whi[1]) begin
                    r_wj <= r_wj + MW'(1);
                end else begin
                    r_wj <= r_wlo[1];
                    r_wi <= r_wi + MW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_set) begin
            r_st <= i_cmd.st_val;
        end else if (i_cmd.walk_wr && fill_full) begin
            r_st <= gpl_pkg::ST_FULL;
        end
    end

    // bucket scan
    logic hit;

    always_comb begin
        hit = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (r_p[a] < $signed(r_blk_rd[191 - 32 * a -: 32]) ||
                r_p[a] > $signed(r_blk_rd[95 - 32 * a -: 32])) hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_get) begin
            r_fill_cnt <= r_fill_rd;
            r_n        <= '0;
        end else if (i_cmd.scan_next) begin
            r_n <= r_n + FW'(1);
        end
        if (i_cmd.hit_ld) begin
            r_blk <= r_ent_rd;
            for (int a = 0; a < 3; a++) begin
                r_bl[a] <= r_blk_rd[191 - 32 * a -: 32];
                r_bh[a] <= r_blk_rd[95 - 32 * a -: 32];
            end
        end
    end

    // cell, fraction and weights
    logic [7:0]  ic_raw [3];
    logic [5:0]  ic [3];
    logic [16:0] fr [3];
    logic [6:0]  cells_n [3];
    logic [5:0]  lin;

    always_comb begin
        cells_n[0] = 7'(CELLS_X);
        cells_n[1] = 7'(CELLS_Y);
        cells_n[2] = 7'(CELLS_Z);
        for (int a = 0; a < 3; a++) begin
            ic_raw[a] = r_cq[a][CQW-1:16];
            if ({1'b0, ic_raw[a]} >= {2'b0, cells_n[a]}) begin
                ic[a] = 6'(cells_n[a] - 7'd1);
                fr[a] = gpl_pkg::ONE_Q16;
            end else begin
                ic[a] = 6'(ic_raw[a]);
                fr[a] = {1'b0, r_cq[a][15:0]};
            end
        end
        lin = 6'(int'(ic[0]) + CELLS_X * (int'(ic[1]) + CELLS_Y * int'(ic[2])));
    end

    logic [16:0] fa;
    logic [16:0] fb;
    logic [16:0] fc;
    logic [16:0] pab;
    logic [33:0] r_ab;
    logic [33:0] r_pc;

    always_comb begin
        fa  = (r_s[0] ^ r_s[1]) ? r_f[0] : gpl_pkg::ONE_Q16 - r_f[0];
        fb  = r_s[1] ? r_f[1] : gpl_pkg::ONE_Q16 - r_f[1];
        fc  = r_s[2] ? r_f[2] : gpl_pkg::ONE_Q16 - r_f[2];
        pab = 17'((r_ab + gpl_pkg::HALF_Q16) >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_ld) begin
            for (int a = 0; a < 3; a++) r_f[a] <= fr[a];
            r_lin <= lin;
        end
        if (i_cmd.cell_ld) begin
            r_s <= '0;
        end else if (i_cmd.emit_w) begin
            r_s <= r_s + 3'd1;
        end
        if (i_cmd.mul1) r_ab <= 34'(fa) * 34'(fb);
        if (i_cmd.mul2) r_pc <= 34'(pab) * 34'(fc);
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_w || i_cmd.emit1) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_w) begin
            o_status     <= gpl_pkg::ST_OK;
            o_slot       <= r_s;
            o_node_index <= r_corner_rd;
            o_weight     <= 17'((r_pc + gpl_pkg::HALF_Q16) >> 16);
            o_last       <= r_s == gpl_pkg::SLOT_LAST;
        end else if (i_cmd.emit1) begin
            o_status     <= r_st;
            o_slot       <= '0;
            o_node_index <= '0;
            o_weight     <= '0;
            o_last       <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_sts            = '0;
        o_sts.act        = r_act;
        o_sts.clr_last   = r_clr == NBW'(NUM_B - 1);
        o_sts.bn_ok      = bn_ok;
        o_sts.outside    = outside;
        o_sts.div_done   = div_done;
        o_sts.div_last   = (r_phase_cell || r_act == gpl_pkg::ACT_QUERY) ?
                           (r_div_idx == 3'd2) : (r_div_idx == 3'd5);
        o_sts.phase_cell = r_phase_cell;
        o_sts.is_query   = r_act == gpl_pkg::ACT_QUERY;
        o_sts.range_ok   = range_ok;
        o_sts.walk_last  = walk_last;
        o_sts.scan_end   = r_n >= r_fill_cnt;
        o_sts.hit        = hit;
        o_sts.s_last     = r_s == gpl_pkg::SLOT_LAST;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end
endmodule

@@ rtl/grid_point_locate_trilinear_unit.sv @@
// Top level of the grid point locator with trilinear weights.
// Uses gpl_pkg; instantiates gpl_ctrl and gpl_dpath.
//
// Input channel (i_in_valid / o_in_ready) takes one transaction at a time:
// register a block's bounds, load one cell corner node, or query a point.
// Output channel (o_out_valid / i_out_ready) returns one result for a
// register or a failed query, eight results (slots 0..7, last on 7) for a
// hit, and nothing for a node load or an unused action. Configuration
// writes go through i_cfg_valid / o_cfg_ready, which is always ready.
// Every division (bucket and cell coordinates) runs in one shared
// bit-serial divider: a register runs six divisions and then walks each
// overlapped bucket, a query runs three divisions, scans the bucket entries
// and, on a hit, runs three more divisions before weighting each result.
// After reset all MAP_SIZE^3 bucket fill counts are cleared, one bucket per
// cycle, with o_in_ready low. A result waits in the output register while
// the receiver stalls; the next transaction is still taken, and its first
// result holds until the register frees.
module grid_point_locate_trilinear_unit #(
    parameter int MAP_SIZE     = 8,
    parameter int CELLS_X      = 4,
    parameter int CELLS_Y      = 4,
    parameter int CELLS_Z      = 4,
    parameter int MAX_BLOCKS   = 64,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [gpl_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]                i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_action,
    input  logic [5:0]                 i_block_number,
    input  logic [5:0]                 i_cell_number,
    input  logic [2:0]                 i_corner_slot,
    input  logic [20:0]                i_node_number,
    input  logic signed [31:0]         i_pos_x,
    input  logic signed [31:0]         i_pos_y,
    input  logic signed [31:0]         i_pos_z,
    input  logic signed [31:0]         i_upper_x,
    input  logic signed [31:0]         i_upper_y,
    input  logic signed [31:0]         i_upper_z,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [2:0]                 o_slot,
    output logic [19:0]                o_node_index,
    output logic [16:0]                o_weight,
    output logic                       o_last
);
    gpl_pkg::t_cmd cmd;
    gpl_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = cmd.in_ready;

    gpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gpl_dpath #(
        .MAP_SIZE     (MAP_SIZE),
        .CELLS_X      (CELLS_X),
        .CELLS_Y      (CELLS_Y),
        .CELLS_Z      (CELLS_Z),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_action),
        .i_block_number (i_block_number),
        .i_cell_number  (i_cell_number),
        .i_corner_slot  (i_corner_slot),
        .i_node_number  (i_node_number),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_upper_x      (i_upper_x),
        .i_upper_y      (i_upper_y),
        .i_upper_z      (i_upper_z),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_node_index   (o_node_index),
        .o_weight       (o_weight),
        .o_last         (o_last)
    );
endmodule

@@ tb/grid_point_locate_trilinear_unit_tb.sv @@
// Self-checking testbench of grid_point_locate_trilinear_unit: block registers,
// corner node loads and point queries against an in-bench lookup/weight predictor.
// Depends on gpl_pkg and the RTL top level.
`timescale 1ns / 1ps

module grid_point_locate_trilinear_unit_tb;

    localparam int MAP      = 8;
    localparam int NCELL    = 4;
    localparam int DEPTH    = 8;
    localparam int SETTLE   = 2000;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         action;
        logic [5:0]         bn;
        logic [5:0]         cell_no;
        logic [2:0]         cs;
        logic [20:0]        node;
        logic signed [31:0] px, py, pz, ux, uy, uz;
    } t_item;

    typedef struct {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [19:0] node;
        logic [16:0] weight;
        logic        last;
    } t_result;

    typedef longint t_vec3[3];

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [gpl_pkg::CFG_IW-1:0] i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_action = '0;
    logic [5:0]         i_block_number = '0;
    logic [5:0]         i_cell_number = '0;
    logic [2:0]         i_corner_slot = '0;
    logic [20:0]        i_node_number = '0;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [31:0] i_upper_x = '0, i_upper_y = '0, i_upper_z = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic [2:0]         o_slot;
    logic [19:0]        o_node_index;
    logic [16:0]        o_weight;
    logic               o_last;

    grid_point_locate_trilinear_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    longint      dom_lo[3], dom_hi[3];
    longint      blk_lo[64][3], blk_hi[64][3];
    logic [19:0] corner_mem[gpl_pkg::CORNER_DEPTH];
    bit          corner_set[gpl_pkg::CORNER_DEPTH];
    logic [5:0]  bucket_blk[MAP*MAP*MAP][DEPTH];
    int          bucket_cnt[MAP*MAP*MAP];
    int          registered[$];

    t_item   pending_items[$];
    t_result expected_results[$];

    int  errors = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  items_queued = 0;
    int  hits = 0, misses = 0, outsides = 0, fulls = 0;
    bit  run_started = 0;
    bit  in_acc = 0;
    bit  out_acc = 0;
    int  in_gap = 0;
    int  out_stall = 0;
    int  hold_cnt = 0;
    bit  hold_done = 0;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint bucket_coord(int a, longint v);
        longint ext;
        ext = dom_hi[a] - dom_lo[a];
        if (ext <= 0) return 0;
        return floor_div((v - dom_lo[a]) * MAP, ext);
    endfunction

    function automatic longint rnd(longint a, longint b);
        longint span;
        longint unsigned r;
        span = b - a + 1;
        if (span <= 0) return a;
        r = {$urandom, $urandom};
        return a + longint'(r % longint'(span));
    endfunction

    // Find the containing block and cell of a point; f holds the fractions.
    function automatic void locate_point(input t_vec3 p, output logic [1:0] st,
                                         output int blk, output int lin,
                                         output t_vec3 f);
        longint bi[3];
        longint ext, q, ic[3];
        int b, c;
        bit found;
        found = 0;
        blk = 0;
        lin = 0;
        f = '{0, 0, 0};
        for (int a = 0; a < 3; a++) begin
            if (p[a] < dom_lo[a] || dom_hi[a] < p[a]) begin
                st = gpl_pkg::ST_OUTSIDE;
                return;
            end
        end
        for (int a = 0; a < 3; a++) begin
            bi[a] = bucket_coord(a, p[a]);
            if (bi[a] < 0) bi[a] = 0;
            if (bi[a] > MAP - 1) bi[a] = MAP - 1;
        end
        b = int'((bi[0] * MAP + bi[1]) * MAP + bi[2]);
        for (int n = 0; n < bucket_cnt[b] && !found; n++) begin
            c = int'(bucket_blk[b][n]);
            if (p[0] >= blk_lo[c][0] && p[0] <= blk_hi[c][0] &&
                p[1] >= blk_lo[c][1] && p[1] <= blk_hi[c][1] &&
                p[2] >= blk_lo[c][2] && p[2] <= blk_hi[c][2]) begin
                found = 1;
                blk = c;
            end
        end
        if (!found) begin
            st = gpl_pkg::ST_NOTFOUND;
            return;
        end
        for (int a = 0; a < 3; a++) begin
            ext = blk_hi[blk][a] - blk_lo[blk][a];
            q = 0;
            if (ext > 0) q = ((p[a] - blk_lo[blk][a]) * NCELL * 65536) / ext;
            ic[a] = q >>> 16;
            f[a] = q & 16'hFFFF;
            if (ic[a] >= NCELL) begin
                ic[a] = NCELL - 1;
                f[a] = 65536;
            end
        end
        lin = int'((ic[0] + NCELL * (ic[1] + NCELL * ic[2])) & 63);
        st = gpl_pkg::ST_OK;
    endfunction

    function automatic void push_result(logic [1:0] st, logic [2:0] s, logic [19:0] nd,
                                        logic [16:0] w, logic lst);
        t_result r;
        r.status = st;
        r.slot = s;
        r.node = nd;
        r.weight = w;
        r.last = lst;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void predict_item(t_item it);
        longint lo[3], hi[3], p[3], u[3];
        longint fa, fb, fc, pr;
        t_vec3 pt, f;
        logic [1:0] st;
        int blk, lin, b, ox, oy, oz;
        bit any;
        p = '{longint'(it.px), longint'(it.py), longint'(it.pz)};
        u = '{longint'(it.ux), longint'(it.uy), longint'(it.uz)};
        case (it.action)
            gpl_pkg::ACT_REG: begin
                st = gpl_pkg::ST_OK;
                any = 1;
                for (int a = 0; a < 3; a++) begin
                    blk_lo[it.bn][a] = p[a];
                    blk_hi[it.bn][a] = u[a];
                    lo[a] = bucket_coord(a, p[a]);
                    hi[a] = bucket_coord(a, u[a]);
                    if (hi[a] < 0 || lo[a] >= MAP) any = 0;
                    if (lo[a] < 0) lo[a] = 0;
                    if (hi[a] > MAP - 1) hi[a] = MAP - 1;
                end
                if (any) begin
                    for (longint i = lo[0]; i <= hi[0]; i++)
                        for (longint j = lo[1]; j <= hi[1]; j++)
                            for (longint k = lo[2]; k <= hi[2]; k++) begin
                                b = int'((i * MAP + j) * MAP + k);
                                if (bucket_cnt[b] >= DEPTH) st = gpl_pkg::ST_FULL;
                                else begin
                                    bucket_blk[b][bucket_cnt[b]] = it.bn;
                                    bucket_cnt[b]++;
                                end
                            end
                end
                if (st == gpl_pkg::ST_FULL) fulls++;
                registered.insert(registered.size(), int'(it.bn));
                push_result(st, 3'd0, 20'd0, 17'd0, 1'b1);
            end
            gpl_pkg::ACT_NODE: begin
                b = (int'(it.bn) * 64 + int'(it.cell_no)) * 8 + int'(it.cs);
                corner_mem[b] = 20'(it.node - 21'd1);
                corner_set[b] = 1;
            end
            gpl_pkg::ACT_QUERY: begin
                pt = '{longint'(it.px), longint'(it.py), longint'(it.pz)};
                locate_point(pt, st, blk, lin, f);
                if (st != gpl_pkg::ST_OK) begin
                    if (st == gpl_pkg::ST_OUTSIDE) outsides++;
                    else misses++;
                    push_result(st, 3'd0, 20'd0, 17'd0, 1'b1);
                end else begin
                    hits++;
                    for (int s = 0; s < 8; s++) begin
                        ox = ((s & 3) == 1 || (s & 3) == 2);
                        oy = ((s & 3) >= 2);
                        oz = s >> 2;
                        fa = ox ? f[0] : 65536 - f[0];
                        fb = oy ? f[1] : 65536 - f[1];
                        fc = oz ? f[2] : 65536 - f[2];
                        pr = (fa * fb + 32768) >>> 16;
                        push_result(gpl_pkg::ST_OK, 3'(s),
                                    corner_mem[(blk * 64 + lin) * 8 + s],
                                    17'((pr * fc + 32768) >>> 16),
                                    s == int'(gpl_pkg::SLOT_LAST));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_item random_fields();
        t_item it;
        it.action = 2'($urandom);
        it.bn = 6'($urandom);
        it.cell_no = 6'($urandom);
        it.cs = 3'($urandom);
        it.node = 21'($urandom);
        it.px = $urandom; it.py = $urandom; it.pz = $urandom;
        it.ux = $urandom; it.uy = $urandom; it.uz = $urandom;
        return it;
    endfunction

    function automatic void push_item(t_item it);
        predict_item(it);
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endfunction

    function automatic void add_block(int bn, t_vec3 lo, t_vec3 hi);
        t_item it;
        it = random_fields();
        it.action = gpl_pkg::ACT_REG;
        it.bn = 6'(bn);
        it.px = 32'(lo[0]); it.py = 32'(lo[1]); it.pz = 32'(lo[2]);
        it.ux = 32'(hi[0]); it.uy = 32'(hi[1]); it.uz = 32'(hi[2]);
        push_item(it);
    endfunction

    function automatic void add_node(int bn, int cell_no, int cs, logic [20:0] nd);
        t_item it;
        it = random_fields();
        it.action = gpl_pkg::ACT_NODE;
        it.bn = 6'(bn);
        it.cell_no = 6'(cell_no);
        it.cs = 3'(cs);
        it.node = nd;
        push_item(it);
    endfunction

    // Load any missing corners of the hit cell first, then send the query.
    function automatic void add_query(t_vec3 p);
        t_item it;
        t_vec3 f;
        logic [1:0] st;
        int blk, lin;
        locate_point(p, st, blk, lin, f);
        if (st == gpl_pkg::ST_OK)
            for (int s = 0; s < 8; s++)
                if (!corner_set[(blk * 64 + lin) * 8 + s])
                    add_node(blk, lin, s, 21'($urandom));
        it = random_fields();
        it.action = gpl_pkg::ACT_QUERY;
        it.px = 32'(p[0]); it.py = 32'(p[1]); it.pz = 32'(p[2]);
        push_item(it);
    endfunction

    function automatic void random_block();
        t_vec3 lo, hi;
        longint t;
        for (int a = 0; a < 3; a++) begin
            if (dom_hi[a] > dom_lo[a] && $urandom_range(0, 9) != 0) begin
                lo[a] = rnd(dom_lo[a], dom_hi[a]);
                hi[a] = rnd(lo[a], $urandom_range(0, 2) == 0 ? dom_hi[a] :
                            lo[a] + (dom_hi[a] - dom_lo[a]) / 3);
                if (hi[a] > I32_MAX) hi[a] = I32_MAX;
            end else begin
                lo[a] = rnd(I32_MIN, I32_MAX);
                hi[a] = rnd(I32_MIN, I32_MAX);
                if (lo[a] > hi[a] && $urandom_range(0, 3) != 0) begin
                    t = lo[a]; lo[a] = hi[a]; hi[a] = t;
                end
            end
        end
        add_block($urandom_range(0, 63), lo, hi);
    endfunction

    function automatic void random_query();
        t_vec3 p;
        int pick, bn;
        pick = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) begin
            if (pick < 7 && registered.size() > 0) begin
                if (a == 0) bn = registered[$urandom_range(0, registered.size() - 1)];
                if (blk_lo[bn][a] <= blk_hi[bn][a]) p[a] = rnd(blk_lo[bn][a], blk_hi[bn][a]);
                else p[a] = blk_lo[bn][a];
            end else if (pick < 9 && dom_hi[a] >= dom_lo[a]) begin
                p[a] = rnd(dom_lo[a], dom_hi[a]);
            end else begin
                p[a] = rnd(I32_MIN, I32_MAX);
            end
        end
        add_query(p);
    endfunction

    // Queue random transactions until the running total reaches upto.
    function automatic void random_items(int upto);
        t_item it;
        int r;
        while (items_queued < upto) begin
            r = $urandom_range(0, 99);
            if (r < 12) random_block();
            else if (r < 24) begin
                it = random_fields();
                it.action = gpl_pkg::ACT_NODE;
                push_item(it);
            end else if (r < 28) begin
                it = random_fields();
                it.action = ACT_UNUSED;
                push_item(it);
            end else random_query();
        end
    endfunction

    task automatic write_reg(int idx, longint val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= gpl_pkg::CFG_IW'(idx);
        i_cfg_data <= 32'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx < 3) dom_lo[idx] = val;
        else dom_hi[idx - 3] = val;
    endtask

    task automatic set_domain(t_vec3 lo, t_vec3 hi);
        for (int a = 0; a < 3; a++) write_reg(a, lo[a]);
        for (int a = 0; a < 3; a++) write_reg(a + 3, hi[a]);
    endtask

    // Node loads give no result, so settle after the last result as well.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // input driver
    always @(negedge i_clk) begin
        t_item it;
        bit take;
        take = 0;
        if (run_started && (!i_in_valid || in_acc)) begin
            if (in_acc) begin
                items_sent++;
                in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end
            if (in_gap > 0) in_gap--;
            else if (pending_items.size() > 0) take = 1;
            if (take) begin
                it = pending_items.pop_front();
                i_action <= it.action;
                i_block_number <= it.bn;
                i_cell_number <= it.cell_no;
                i_corner_slot <= it.cs;
                i_node_number <= it.node;
                i_pos_x <= it.px; i_pos_y <= it.py; i_pos_z <= it.pz;
                i_upper_x <= it.ux; i_upper_y <= it.uy; i_upper_z <= it.uz;
            end
            i_in_valid <= take;
        end
    end

    // result receiver: per-result stall plus one long hold-off
    always @(negedge i_clk) begin
        if (!hold_done && results_seen >= 150) begin
            hold_cnt <= 3000;
            hold_done <= 1;
        end else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end

    always @(negedge i_clk) begin
        if (out_acc)
            out_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        else if (out_stall > 0) out_stall--;
        i_out_ready <= i_rst_n && out_stall == 0 && hold_cnt == 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        in_acc <= i_in_valid && o_in_ready;
        out_acc <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report("unexpected result, status", o_status, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status) report("status", o_status, want.status);
                if (o_slot !== want.slot) report("slot", o_slot, want.slot);
                if (o_node_index !== want.node) report("node_index", o_node_index, want.node);
                if (o_weight !== want.weight) report("weight", o_weight, want.weight);
                if (o_last !== want.last) report("last", o_last, want.last);
            end
        end
    end

    initial begin
        #100ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_vec3 lo, hi, p;
        t_item it;
        for (int b = 0; b < MAP * MAP * MAP; b++) bucket_cnt[b] = 0;
        dom_lo = '{0, 0, 0};
        dom_hi = '{65536, 65536, 65536};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default unit domain: octant tiling, edge blocks, edge points
        set_domain('{0, 0, 0}, '{65536, 65536, 65536});
        for (int o = 0; o < 8; o++) begin
            lo = '{(o & 1) * 32768, ((o >> 1) & 1) * 32768, (o >> 2) * 32768};
            hi = '{lo[0] + 32768, lo[1] + 32768, lo[2] + 32768};
            add_block(o, lo, hi);
        end
        add_block(8, '{1000, 0, 0}, '{1000, 65536, 65536});
        add_block(9, '{40000, 0, 0}, '{20000, 65536, 65536});
        add_block(10, '{-200000, 0, 0}, '{-100000, 65536, 65536});
        add_node(0, 0, 0, 21'd0);
        add_node(0, 0, 1, 21'h1FFFFF);
        add_query('{0, 0, 0});
        add_query('{65536, 65536, 65536});
        add_query('{32768, 32768, 32768});
        add_query('{12345, 54321, 777});
        add_query('{-1, 0, 0});
        add_query('{0, 65537, 0});
        add_query('{1000, 5, 5});
        it = random_fields();
        it.action = ACT_UNUSED;
        push_item(it);
        for (int k = 11; k < 21; k++) add_block(k, '{0, 0, 0}, '{65536, 65536, 65536});
        add_query('{60000, 100, 30000});
        run_started = 1;
        random_items(170);
        wait_drained();

        // widest signed domain
        set_domain('{I32_MIN, I32_MIN, I32_MIN}, '{I32_MAX, I32_MAX, I32_MAX});
        add_block(30, '{I32_MIN, I32_MIN, I32_MIN}, '{I32_MAX, I32_MAX, I32_MAX});
        add_query('{I32_MIN, I32_MIN, I32_MIN});
        add_query('{I32_MAX, I32_MAX, I32_MAX});
        random_items(280);
        wait_drained();

        // random offset domain
        for (int a = 0; a < 3; a++) begin
            lo[a] = rnd(-1000000000, 0);
            hi[a] = rnd(1, 1000000000);
        end
        set_domain(lo, hi);
        random_items(370);
        wait_drained();

        // zero extent on x, negative extent on y
        set_domain('{5000, 70000, -3}, '{5000, 10, 900000});
        p = '{5000, 20, 0};
        add_query(p);
        random_items(410);
        wait_drained();

        set_domain('{-65536, -65536, -65536}, '{65536, 65536, 65536});
        random_items(480);
        wait_drained();

        $display("covered %0d transactions, %0d results: %0d hits, %0d not found,",
                 items_sent, results_seen, hits, misses);
        $display("%0d outside, %0d bucket-full registers over five domain settings",
                 outsides, fulls);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
